// File: design/rdi_pkg.sv
// ----------------------------------------------------------------------------
// rdi_pkg
// Shared widths, register indexes and pipeline types of the ray/disc
// intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package rdi_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS     = 16;
  localparam int COORD_WIDTH   = 32;
  localparam int NORM_WIDTH    = 18;
  localparam int RAD_WIDTH     = 31;
  localparam int THR_WIDTH     = 17;
  localparam int T_WIDTH       = 31;
  localparam int CFG_IDX_WIDTH = 4;

  // Derived datapath widths
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PD_WIDTH    = NORM_WIDTH + COORD_WIDTH;
  localparam int PN_WIDTH    = NORM_WIDTH + DIFF_WIDTH;
  localparam int NUM_WIDTH   = PN_WIDTH + 2;
  localparam int OVF_SHIFT   = T_WIDTH - FRAC_BITS;
  localparam int MUL_WIDTH   = COORD_WIDTH + T_WIDTH;
  localparam int P_WIDTH     = MUL_WIDTH - FRAC_BITS;
  localparam int AE_WIDTH    = P_WIDTH + 2;
  localparam int SQ_WIDTH    = 2 * T_WIDTH;
  localparam int SUM_WIDTH   = SQ_WIDTH + 2;
  localparam int IN_WIDTH    = 6 * COORD_WIDTH;
  localparam int OUT_WIDTH   = ((T_WIDTH + 2 + 7) / 8) * 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CENTER_X  = 4'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CENTER_Y  = 4'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_CENTER_Z  = 4'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_NORMAL_X  = 4'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_NORMAL_Y  = 4'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_NORMAL_Z  = 4'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_RADIUS    = 4'd6;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_THRESHOLD = 4'd7;

  // Per-item control that travels with the data
  typedef struct packed {
    logic valid;
    logic miss;
    logic ovf;
  } rdi_ctl_t;

  // Ray data carried past the divider
  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] dir;
    logic [2:0][DIFF_WIDTH-1:0]  off;
  } rdi_ray_t;

endpackage

`default_nettype wire

// File: design/rdi_dot.sv
// ----------------------------------------------------------------------------
// rdi_dot
// Front stages: dot products n.d and n.(c-o), parallel, sign and overflow
// tests, and the divider's starting remainder. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module rdi_dot
  import rdi_pkg::*;
(
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               adv,
  input  wire logic                               in_valid,
  input  wire logic [2:0][COORD_WIDTH-1:0]        origin,
  input  wire logic [2:0][COORD_WIDTH-1:0]        dir,
  input  wire logic [2:0][COORD_WIDTH-1:0]        center,
  input  wire logic [2:0][NORM_WIDTH-1:0]         normal,
  input  wire logic [THR_WIDTH-1:0]               threshold,
  output rdi_ctl_t                                ctl,
  output logic [NUM_WIDTH-1:0]                    rem,
  output logic [NUM_WIDTH-1:0]                    aden,
  output logic [OVF_SHIFT-1:0]                    low,
  output rdi_ray_t                                ray
);

  logic signed [DIFF_WIDTH-1:0] diff [3];
  logic signed [PD_WIDTH-1:0]   pd_next [3];
  logic signed [PN_WIDTH-1:0]   pn_next [3];

  logic signed [PD_WIDTH-1:0]   pd [3];
  logic signed [PN_WIDTH-1:0]   pn [3];
  logic                         valid1;
  rdi_ray_t                     ray1;

  logic signed [NUM_WIDTH-1:0]  den;
  logic signed [NUM_WIDTH-1:0]  num;
  logic                         valid2;
  rdi_ray_t                     ray2;

  logic [NUM_WIDTH-1:0]         aden_next;
  logic [NUM_WIDTH-1:0]         anum_next;
  logic                         par_miss;
  logic                         neg_miss;
  logic                         quo_ovf;
  rdi_ray_t                     ray1_next;

  // Stage 1: differences and products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = $signed({center[i][COORD_WIDTH-1], center[i]})
              - $signed({origin[i][COORD_WIDTH-1], origin[i]});
      pd_next[i] = $signed(normal[i]) * $signed(dir[i]);
      pn_next[i] = $signed(normal[i]) * diff[i];
      ray1_next.dir[i] = dir[i];
      ray1_next.off[i] = DIFF_WIDTH'(-diff[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (adv) begin
      valid1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pd   <= pd_next;
      pn   <= pn_next;
      ray1 <= ray1_next;
    end
  end

  // Stage 2: sum the products
  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (adv) begin
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den  <= NUM_WIDTH'(pd[0]) + NUM_WIDTH'(pd[1]) + NUM_WIDTH'(pd[2]);
      num  <= NUM_WIDTH'(pn[0]) + NUM_WIDTH'(pn[1]) + NUM_WIDTH'(pn[2]);
      ray2 <= ray1;
    end
  end

  // Stage 3: magnitudes and early-out tests
  always_comb begin
    aden_next = den[NUM_WIDTH-1] ? NUM_WIDTH'(-den) : NUM_WIDTH'(den);
    anum_next = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
    par_miss  = (den == '0) ||
                (aden_next < NUM_WIDTH'({threshold, {FRAC_BITS{1'b0}}}));
    neg_miss  = (num != '0) && (num[NUM_WIDTH-1] != den[NUM_WIDTH-1]);
    quo_ovf   = (anum_next >> OVF_SHIFT) >= aden_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (adv) begin
      ctl.valid <= valid2;
      ctl.miss  <= par_miss | neg_miss | quo_ovf;
      ctl.ovf   <= ~par_miss & ~neg_miss & quo_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem  <= anum_next >> OVF_SHIFT;
      aden <= aden_next;
      low  <= anum_next[OVF_SHIFT-1:0];
      ray  <= ray2;
    end
  end

endmodule

`default_nettype wire

// File: design/rdi_div.sv
// ----------------------------------------------------------------------------
// rdi_div
// One restoring division step: shift in the next dividend bit, compare with
// |n.d|, subtract and set one quotient bit. One register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rdi_div
  import rdi_pkg::*;
#(
  parameter int BIT = 0
)
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire rdi_ctl_t             ctl_in,
  input  wire logic [NUM_WIDTH-1:0] rem_in,
  input  wire logic [NUM_WIDTH-1:0] den_in,
  input  wire logic [OVF_SHIFT-1:0] low_in,
  input  wire logic [T_WIDTH-1:0]   q_in,
  input  wire rdi_ray_t             ray_in,
  output rdi_ctl_t                  ctl_out,
  output logic [NUM_WIDTH-1:0]      rem_out,
  output logic [NUM_WIDTH-1:0]      den_out,
  output logic [OVF_SHIFT-1:0]      low_out,
  output logic [T_WIDTH-1:0]        q_out,
  output rdi_ray_t                  ray_out
);

  logic                 bring;
  logic [NUM_WIDTH:0]   shifted;
  logic [NUM_WIDTH:0]   diff;
  logic                 ge;

  // Dividend bit entering at this step: |n.(c-o)| shifted left by FRAC_BITS
  if (BIT >= FRAC_BITS) begin : g_data_bit
    assign bring = low_in[BIT-FRAC_BITS];
  end else begin : g_zero_bit
    assign bring = 1'b0;
  end

  always_comb begin
    shifted = {rem_in, bring};
    diff    = shifted - {1'b0, den_in};
    ge      = shifted >= {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_out <= ge ? diff[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
      den_out <= den_in;
      low_out <= low_in;
      q_out   <= {q_in[T_WIDTH-2:0], ge};
      ray_out <= ray_in;
    end
  end

endmodule

`default_nettype wire

// File: design/rdi_check.sv
// ----------------------------------------------------------------------------
// rdi_check
// Back stages: hit point offset (o-c) + d*t, squared distance and compare
// against r*r. Four register stages, the last one is the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdi_check
  import rdi_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire rdi_ctl_t             ctl_in,
  input  wire logic [T_WIDTH-1:0]   q_in,
  input  wire rdi_ray_t             ray_in,
  input  wire logic [RAD_WIDTH-1:0] radius,
  output logic                      out_valid,
  output logic                      hit,
  output logic [T_WIDTH-1:0]        hit_distance,
  output logic                      overflow
);

  logic [COORD_WIDTH-1:0]       dmag [3];
  logic [MUL_WIDTH-1:0]         prod [3];

  // Stage A registers
  rdi_ctl_t                     ctl_a;
  logic [T_WIDTH-1:0]           q_a;
  logic [P_WIDTH-1:0]           p_a [3];
  logic                         neg_a [3];
  logic [DIFF_WIDTH-1:0]        off_a [3];

  logic signed [AE_WIDTH-1:0]   dt [3];
  logic signed [AE_WIDTH-1:0]   ae [3];
  logic [AE_WIDTH-1:0]          amag [3];
  logic                         big_next;

  // Stage B registers
  rdi_ctl_t                     ctl_b;
  logic [T_WIDTH-1:0]           q_b;
  logic [T_WIDTH-1:0]           amag_b [3];
  logic                         big_b;

  // Stage C registers
  rdi_ctl_t                     ctl_c;
  logic [T_WIDTH-1:0]           q_c;
  logic [SQ_WIDTH-1:0]          sq_c [3];
  logic                         big_c;
  logic [SQ_WIDTH-1:0]          rsq;

  logic [SUM_WIDTH-1:0]         sum;
  logic                         hit_next;

  // Stage A: |d| * t, truncated to FRAC_BITS
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i] = ray_in.dir[i][COORD_WIDTH-1] ? (~ray_in.dir[i] + 1'b1) : ray_in.dir[i];
      prod[i] = MUL_WIDTH'(dmag[i]) * MUL_WIDTH'(q_in);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else if (adv) begin
      ctl_a <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_a <= q_in;
      for (int i = 0; i < 3; i++) begin
        p_a[i]   <= prod[i][MUL_WIDTH-1:FRAC_BITS];
        neg_a[i] <= ray_in.dir[i][COORD_WIDTH-1];
        off_a[i] <= ray_in.off[i];
      end
    end
  end

  // Stage B: offset from the centre and its magnitude
  always_comb begin
    big_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dt[i]   = neg_a[i] ? -$signed({2'b00, p_a[i]}) : $signed({2'b00, p_a[i]});
      ae[i]   = AE_WIDTH'($signed(off_a[i])) + dt[i];
      amag[i] = ae[i][AE_WIDTH-1] ? AE_WIDTH'(-ae[i]) : AE_WIDTH'(ae[i]);
      big_next = big_next | (|amag[i][AE_WIDTH-1:T_WIDTH]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b <= '0;
    end else if (adv) begin
      ctl_b <= ctl_a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_b   <= q_a;
      big_b <= big_next;
      for (int i = 0; i < 3; i++) begin
        amag_b[i] <= amag[i][T_WIDTH-1:0];
      end
    end
  end

  // Stage C: squares; r*r held in its own register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_c <= '0;
    end else if (adv) begin
      ctl_c <= ctl_b;
    end
  end

  always_ff @(posedge clk) begin
    rsq <= SQ_WIDTH'(radius) * SQ_WIDTH'(radius);
    if (adv) begin
      q_c   <= q_b;
      big_c <= big_b;
      for (int i = 0; i < 3; i++) begin
        sq_c[i] <= SQ_WIDTH'(amag_b[i]) * SQ_WIDTH'(amag_b[i]);
      end
    end
  end

  // Stage D: sum, compare and form the result
  always_comb begin
    sum      = SUM_WIDTH'(sq_c[0]) + SUM_WIDTH'(sq_c[1]) + SUM_WIDTH'(sq_c[2]);
    hit_next = ~ctl_c.miss & ~big_c & (sum <= SUM_WIDTH'(rsq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl_c.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit          <= hit_next;
      hit_distance <= hit_next ? q_c : '0;
      overflow     <= ctl_c.ovf;
    end
  end

endmodule

`default_nettype wire

// File: design/ray_disc_intersection.sv
// ----------------------------------------------------------------------------
// ray_disc_intersection
// Configured-disc ray test, fully pipelined, one ray/clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one ray per clock on the s_ side while s_tready is up and returns
// one result per ray on the m_ side, in order, through three stages
// for the dot products and early-out tests, 31 stages of the restoring
// divider (one quotient bit per stage), and four stages for the hit point,
// the squared distance and the result register. A two-entry output path
// (result register plus skid register) lets the pipeline keep moving while
// a result waits; s_tready drops only while the skid register is full.
// Write the disc registers only while no ray is in flight.
`default_nettype none

module ray_disc_intersection
  import rdi_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // ray in
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  wire logic [IN_WIDTH-1:0]      s_tdata,
  // result out
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // hit, hit_distance, overflow, zero padding
  output logic [OUT_WIDTH-1:0]          m_tdata,
  // register writes
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [COORD_WIDTH-1:0]   cfg_data
);

  localparam int STAGES = T_WIDTH;

  logic [2:0][COORD_WIDTH-1:0] center;
  logic [2:0][NORM_WIDTH-1:0]  normal;
  logic [RAD_WIDTH-1:0]        radius;
  logic [THR_WIDTH-1:0]        threshold;

  logic                        adv;
  logic [2:0][COORD_WIDTH-1:0] origin;
  logic [2:0][COORD_WIDTH-1:0] dir;

  rdi_ctl_t                    ctl_s [STAGES+1];
  logic [NUM_WIDTH-1:0]        rem_s [STAGES+1];
  logic [NUM_WIDTH-1:0]        den_s [STAGES+1];
  logic [OVF_SHIFT-1:0]        low_s [STAGES+1];
  logic [T_WIDTH-1:0]          q_s   [STAGES+1];
  rdi_ray_t                    ray_s [STAGES+1];

  logic                        out_valid;
  logic                        out_hit;
  logic [T_WIDTH-1:0]          out_dist;
  logic                        out_ovf;
  logic                        skid_valid;
  logic [OUT_WIDTH-1:0]        skid_data;
  logic [OUT_WIDTH-1:0]        out_data;

  // Register writes; indexes past the list are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center    <= '0;
      normal    <= {NORM_WIDTH'(0), NORM_WIDTH'(1 << FRAC_BITS), NORM_WIDTH'(0)};
      radius    <= '0;
      threshold <= THR_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CENTER_X:  center[0] <= cfg_data;
        CFG_CENTER_Y:  center[1] <= cfg_data;
        CFG_CENTER_Z:  center[2] <= cfg_data;
        CFG_NORMAL_X:  normal[0] <= cfg_data[NORM_WIDTH-1:0];
        CFG_NORMAL_Y:  normal[1] <= cfg_data[NORM_WIDTH-1:0];
        CFG_NORMAL_Z:  normal[2] <= cfg_data[NORM_WIDTH-1:0];
        CFG_RADIUS:    radius    <= cfg_data[RAD_WIDTH-1:0];
        CFG_THRESHOLD: threshold <= cfg_data[THR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the skid register is free
  assign adv      = ~skid_valid;
  assign s_tready = adv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      origin[i] = s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
      dir[i]    = s_tdata[(i+3)*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  rdi_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_tvalid),
    .origin    (origin),
    .dir       (dir),
    .center    (center),
    .normal    (normal),
    .threshold (threshold),
    .ctl       (ctl_s[0]),
    .rem       (rem_s[0]),
    .aden      (den_s[0]),
    .low       (low_s[0]),
    .ray       (ray_s[0])
  );

  assign q_s[0] = '0;

  // Divider chain, most significant quotient bit first
  for (genvar k = 0; k < STAGES; k++) begin : g_div
    rdi_div #(
      .BIT (STAGES - 1 - k)
    ) u_div (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .ctl_in  (ctl_s[k]),
      .rem_in  (rem_s[k]),
      .den_in  (den_s[k]),
      .low_in  (low_s[k]),
      .q_in    (q_s[k]),
      .ray_in  (ray_s[k]),
      .ctl_out (ctl_s[k+1]),
      .rem_out (rem_s[k+1]),
      .den_out (den_s[k+1]),
      .low_out (low_s[k+1]),
      .q_out   (q_s[k+1]),
      .ray_out (ray_s[k+1])
    );
  end

  rdi_check u_check (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .ctl_in       (ctl_s[STAGES]),
    .q_in         (q_s[STAGES]),
    .ray_in       (ray_s[STAGES]),
    .radius       (radius),
    .out_valid    (out_valid),
    .hit          (out_hit),
    .hit_distance (out_dist),
    .overflow     (out_ovf)
  );

  assign out_data = OUT_WIDTH'({out_ovf, out_dist, out_hit});

  // Skid register: catch the result register when it shifts on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (out_valid && !m_tready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_data <= out_data;
    end
  end

  assign m_tvalid = skid_valid | out_valid;
  assign m_tdata  = skid_valid ? skid_data : out_data;

endmodule

`default_nettype wire

// File: dv/ray_disc_intersection_tb.sv
// ----------------------------------------------------------------------------
// ray_disc_intersection_tb
// Streams rays into the disc test over several disc settings and checks each
// result with a local bit-exact model of the intersection math or a typed one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_disc_intersection_tb;
  import rdi_pkg::*;

  localparam int LATENCY   = 38;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 650;

  typedef struct packed {
    logic        hit;
    logic [30:0] distance;
    logic        ovf;
  } hit_t;

  typedef struct {
    logic [31:0] ox, oy, oz, dx, dy, dz;
    logic        chk;
    hit_t        res;
  } ray_row_t;

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [IN_WIDTH-1:0]      s_tdata;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [OUT_WIDTH-1:0]     m_tdata;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [COORD_WIDTH-1:0]   cfg_data;

  // disc registers as the block should hold them
  logic signed [31:0] disc_c [3];
  logic signed [17:0] disc_n [3];
  logic [30:0]        disc_r;
  logic [16:0]        disc_thr;

  hit_t   hits_pending[$];
  int     mismatches;
  int     wdog;
  int     send_idle;
  int     recv_idle;

  ray_disc_intersection u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Compute the expected result of one ray against the current disc
  function automatic hit_t disc_hit(input logic [31:0] ox, oy, oz, dx, dy, dz);
    logic signed [127:0] o [3];
    logic signed [127:0] d [3];
    logic signed [127:0] den, num, dt, e;
    logic [127:0] aden, anum, q, ae, p, sum, r2;
    hit_t res;
    int i;
    res = '0;
    o[0] = $signed(ox); o[1] = $signed(oy); o[2] = $signed(oz);
    d[0] = $signed(dx); d[1] = $signed(dy); d[2] = $signed(dz);
    den = 0;
    num = 0;
    for (i = 0; i < 3; i++) begin
      den += 128'(disc_n[i]) * d[i];
      num += 128'(disc_n[i]) * (128'(disc_c[i]) - o[i]);
    end
    aden = (den < 0) ? -den : den;
    anum = (num < 0) ? -num : num;
    if (den == 0 || aden < ({111'd0, disc_thr} << FRAC_BITS)) return res;
    if (num != 0 && ((num < 0) != (den < 0))) return res;
    q = (anum << FRAC_BITS) / aden;
    if (q >= (128'd1 << 31)) begin
      res.ovf = 1'b1;
      return res;
    end
    sum = 0;
    for (i = 0; i < 3; i++) begin
      p = (((d[i] < 0) ? -d[i] : d[i]) * q) >> FRAC_BITS;
      dt = (d[i] < 0) ? -$signed(p) : $signed(p);
      e = (o[i] - 128'(disc_c[i])) + dt;
      ae = (e < 0) ? -e : e;
      if (ae >= (128'd1 << 31)) return res;
      sum += ae * ae;
    end
    r2 = 128'(disc_r) * 128'(disc_r);
    if (sum > r2) return res;
    res.hit      = 1'b1;
    res.distance = q[30:0];
    return res;
  endfunction

  // Write one disc register and mirror it; valid stays up for the next write
  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    case (idx)
      CFG_CENTER_X:  disc_c[0] = val;
      CFG_CENTER_Y:  disc_c[1] = val;
      CFG_CENTER_Z:  disc_c[2] = val;
      CFG_NORMAL_X:  disc_n[0] = val[17:0];
      CFG_NORMAL_Y:  disc_n[1] = val[17:0];
      CFG_NORMAL_Z:  disc_n[2] = val[17:0];
      CFG_RADIUS:    disc_r    = val[30:0];
      CFG_THRESHOLD: disc_thr  = val[16:0];
      default: ;
    endcase
  endtask

  task automatic set_disc(input logic [31:0] cx, cy, cz, nx, ny, nz, r, thr);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_NORMAL_X, nx);
    write_reg(CFG_NORMAL_Y, ny);
    write_reg(CFG_NORMAL_Z, nz);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_THRESHOLD, thr);
    cfg_valid <= 1'b0;
  endtask

  // Send one ray; queue its expectation at the transfer. Valid stays up
  // after the transfer so that rays can follow back to back.
  task automatic send_ray(input logic [31:0] ox, oy, oz, dx, dy, dz,
                          input logic chk, input hit_t typed);
    hit_t exp_res;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    exp_res = disc_hit(ox, oy, oz, dx, dy, dz);
    if (chk) exp_res = typed;
    s_tvalid <= 1'b1;
    s_tdata  <= {dz, dy, dx, oz, oy, ox};
    do @(posedge clk); while (!s_tready);
    hits_pending.push_back(exp_res);
    @(negedge clk);
  endtask

  // Stop sending, wait for the pipeline to drain, then the block's latency
  task automatic drain();
    s_tvalid <= 1'b0;
    while (hits_pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
    endcase
  endfunction

  // Random ray, mostly aimed near the disc centre so that hits are frequent
  task automatic send_random_ray();
    logic [31:0] o [3];
    logic [31:0] d [3];
    logic [31:0] t;
    int i;
    if ($urandom_range(3) == 0) begin
      for (i = 0; i < 3; i++) begin
        o[i] = rnd_coord();
        d[i] = rnd_coord();
      end
    end else begin
      t = $urandom_range(8 << 16);
      for (i = 0; i < 3; i++) begin
        d[i] = 32'($signed($urandom_range(4 << 16)) - (2 << 16));
        o[i] = disc_c[i] - 32'((longint'($signed(d[i])) * t) >>> 16)
               + 32'($signed($urandom_range(6 << 16)) - (3 << 16));
      end
    end
    send_ray(o[0], o[1], o[2], d[0], d[1], d[2], 1'b0, '0);
  endtask

  // Receiver: random stall, check each result transfer
  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    hit_t got, want;
    if (rst) begin
      wdog <= 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        wdog <= 0;
      else
        wdog <= wdog + 1;
      if (m_tvalid && m_tready) begin
        got.hit      = m_tdata[0];
        got.distance = m_tdata[31:1];
        got.ovf      = m_tdata[32];
        if (hits_pending.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = hits_pending.pop_front();
          if (got !== want || m_tdata[OUT_WIDTH-1:33] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp hit=%0b t=%h ovf=%0b, got hit=%0b t=%h ovf=%0b",
                       want.hit, want.distance, want.ovf, got.hit, got.distance, got.ovf);
          end
        end
      end
      if (wdog >= WDOG_MAX) begin
        $display("ray_disc_intersection_tb NOT OK");
        $finish;
      end
    end
  end

  ray_row_t rows[$];
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MONE = 32'hFFFF_0000;

  function automatic ray_row_t row(input logic [31:0] ox, oy, oz, dx, dy, dz,
                                   input logic chk, input hit_t res);
    ray_row_t r;
    r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
    r.chk = chk; r.res = res;
    return r;
  endfunction

  initial begin
    int ph, k;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    send_idle = 0;
    recv_idle = 0;
    disc_c = '{0, 0, 0};
    disc_n = '{0, 18'sd65536, 0};
    disc_r = 0;
    disc_thr = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table; reset disc is the y=0 plane with zero radius
    // straight down onto the centre: t = 1.0, hit with distance t = 1.0
    rows.push_back(row(0, ONE, 0, 0, MONE, 0, 1'b1, '{1'b1, 31'h10000, 1'b0}));
    // parallel ray
    rows.push_back(row(0, ONE, 0, ONE, 0, 0, 1'b1, '0));
    // pointing away: negative t
    rows.push_back(row(0, ONE, 0, 0, ONE, 0, 1'b1, '0));
    // origin on the plane, t = 0, hit
    rows.push_back(row(0, 0, 0, 0, ONE, 0, 1'b1, '{1'b1, 31'd0, 1'b0}));
    // off centre with zero radius: miss
    rows.push_back(row(ONE, ONE, 0, 0, MONE, 0, 1'b1, '0));
    // tiny direction, far origin: quotient overflow
    rows.push_back(row(0, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 0, 1'b1, '{1'b0, 31'd0, 1'b1}));
    // extremes of every field
    rows.push_back(row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0));
    rows.push_back(row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0));
    rows.push_back(row(32'hFFFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1'b0, '0));
    rows.push_back(row(0, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0));
    foreach (rows[i])
      send_ray(rows[i].ox, rows[i].oy, rows[i].oz, rows[i].dx, rows[i].dy, rows[i].dz,
               rows[i].chk, rows[i].res);
    drain();

    // tilted disc, zero threshold, large offset hit point overflow cases
    set_disc(0, 0, 0, 32'h0000_B505, 0, 32'h0000_B505, 32'h7FFF_FFFF, 0);
    rows.delete();
    rows.push_back(row(0, 0, 0, ONE, 0, 32'hFFFF_0000, 1'b1, '0));
    rows.push_back(row(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b0, '0));
    rows.push_back(row(ONE, 0, ONE, MONE, 32'h7FFF_FFFF, MONE, 1'b0, '0));
    foreach (rows[i])
      send_ray(rows[i].ox, rows[i].oy, rows[i].oz, rows[i].dx, rows[i].dy, rows[i].dz,
               rows[i].chk, rows[i].res);
    drain();

    // Random phases over several disc settings and idle patterns
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_disc(32'h0003_0000, 32'hFFFE_0000, 32'h0001_8000,
                    0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0000_0100);
        1: set_disc($urandom, $urandom, $urandom, 32'h3_FFFF & 32'h3_0000,
                    32'h0000_8000, 32'h0000_DDB4, 32'h7FFF_FFFF, 32'h0001_0000);
        2: set_disc(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_0000,
                    0, 0, 32'h0010_0000, 1);
        default: set_disc(32'hFFFF_8000, 32'h0000_4000, 32'h0002_0000,
                          32'h0000_93CD, 32'hFFFF_6C33, 32'h0000_93CD,
                          32'h0004_0000, $urandom_range(3));
      endcase
      case (ph)
        0: begin send_idle = 33; recv_idle = 82; end
        1: begin send_idle = 82; recv_idle = 33; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (k = 0; k < N_RANDOM / 4; k++) begin
        send_random_ray();
        // hold off until the pipe is empty once per phase
        if (k == 40) begin
          s_tvalid <= 1'b0;
          while (hits_pending.size() != 0) @(negedge clk);
        end
      end
      drain();
    end

    if (mismatches == 0 && hits_pending.size() == 0)
      $display("ray_disc_intersection_tb OK");
    else
      $display("ray_disc_intersection_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
